FILE: hdl/rrd_pkg.sv
`timescale 1ns / 1ps

package rrd_pkg;

	// Parser phases, one-hot
	typedef enum logic [10:0] {
		PH_CNT_HI  = 11'b000_0000_0001,
		PH_CNT_LO  = 11'b000_0000_0010,
		PH_CMD     = 11'b000_0000_0100,
		PH_RLEN_HI = 11'b000_0000_1000,
		PH_RLEN_LO = 11'b000_0001_0000,
		PH_LLEN_HI = 11'b000_0010_0000,
		PH_LLEN_LO = 11'b000_0100_0000,
		PH_REP_HI  = 11'b000_1000_0000,
		PH_REP_LO  = 11'b001_0000_0000,
		PH_LIT_HI  = 11'b010_0000_0000,
		PH_LIT_LO  = 11'b100_0000_0000
	} rrd_phase_t;

	// Command byte codes
	localparam logic [7:0] CMD_REP_LONG = 8'h00;
	localparam logic [7:0] CMD_LIT_LONG = 8'h01;

	// Short literal run length is LIT_BASE minus the low seven bits
	localparam logic [7:0] LIT_BASE = 8'd128;

	// Reset value of the output budget register
	localparam logic [15:0] BUDGET_RESET = 16'd32256;

	// Configuration register indexes
	localparam logic REG_WORD_MODE = 1'b0;
	localparam logic REG_BUDGET    = 1'b1;

	// One decoded result from the parser
	typedef struct packed {
		logic        emit;
		logic [15:0] value;
		logic [15:0] run;
		logic        last;
	} rrd_result_t;

endpackage

FILE: hdl/rrd_parser.sv
`timescale 1ns / 1ps

module rrd_parser
	import rrd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic [7:0]  in_byte,
	input  logic        word_mode,
	input  logic [15:0] output_budget,
	output rrd_result_t res
);

	rrd_phase_t  phase_q, phase_d;
	logic [15:0] cmds_q, cmds_d;
	logic [15:0] budget_q, budget_d;
	logic [15:0] pend_q, pend_d;
	logic [7:0]  held_q, held_d;

	logic [15:0] cmds_dec;
	logic [15:0] pend_dec;
	logic [15:0] run_req;
	logic [15:0] run_clip;
	logic [15:0] budget_after;
	logic [15:0] elem;
	logic        long_len;

	// Requested run length: 16-bit count, short literal or short repeat
	assign long_len = (phase_q == PH_RLEN_LO) || (phase_q == PH_LLEN_LO);
	always_comb begin
		if (long_len) begin
			run_req = {held_q, in_byte};
		end else if (in_byte[7]) begin
			run_req = {8'd0, LIT_BASE - {1'b0, in_byte[6:0]}};
		end else begin
			run_req = {9'd0, in_byte[6:0]};
		end
	end

	// Clip to remaining budget
	assign run_clip     = (run_req > budget_q) ? budget_q : run_req;
	assign budget_after = budget_q - run_clip;

	assign cmds_dec = cmds_q - 16'd1;
	assign pend_dec = pend_q - 16'd1;
	assign elem     = word_mode ? {held_q, in_byte} : {8'd0, in_byte};

	// Next state and result for the byte in hand
	always_comb begin
		phase_d  = phase_q;
		cmds_d   = cmds_q;
		budget_d = budget_q;
		pend_d   = pend_q;
		held_d   = held_q;
		res      = '0;
		case (phase_q)
			PH_CNT_LO: begin
				cmds_d   = {held_q, in_byte};
				budget_d = output_budget;
				if ({held_q, in_byte} == 16'd0) begin
					phase_d  = PH_CNT_HI;
					res.emit = 1'b1;
					res.last = 1'b1;
				end else begin
					phase_d = PH_CMD;
				end
			end
			PH_CMD: begin
				cmds_d = cmds_dec;
				if (in_byte == CMD_REP_LONG) begin
					phase_d = PH_RLEN_HI;
				end else if (in_byte == CMD_LIT_LONG) begin
					phase_d = PH_LLEN_HI;
				end else if (in_byte[7]) begin
					// short literal run
					pend_d   = run_clip;
					budget_d = budget_after;
					if (run_clip != 16'd0) begin
						phase_d = word_mode ? PH_LIT_HI : PH_LIT_LO;
					end else begin
						phase_d  = (cmds_dec == 16'd0) ? PH_CNT_HI : PH_CMD;
						res.emit = (cmds_dec == 16'd0);
						res.last = (cmds_dec == 16'd0);
					end
				end else begin
					// short repeat run
					pend_d   = run_clip;
					budget_d = budget_after;
					phase_d  = word_mode ? PH_REP_HI : PH_REP_LO;
				end
			end
			PH_RLEN_HI: begin
				held_d  = in_byte;
				phase_d = PH_RLEN_LO;
			end
			PH_LLEN_HI: begin
				held_d  = in_byte;
				phase_d = PH_LLEN_LO;
			end
			PH_RLEN_LO: begin
				pend_d   = run_clip;
				budget_d = budget_after;
				phase_d  = word_mode ? PH_REP_HI : PH_REP_LO;
			end
			PH_LLEN_LO: begin
				pend_d   = run_clip;
				budget_d = budget_after;
				if (run_clip != 16'd0) begin
					phase_d = word_mode ? PH_LIT_HI : PH_LIT_LO;
				end else begin
					phase_d  = (cmds_q == 16'd0) ? PH_CNT_HI : PH_CMD;
					res.emit = (cmds_q == 16'd0);
					res.last = (cmds_q == 16'd0);
				end
			end
			PH_REP_HI: begin
				held_d  = in_byte;
				phase_d = PH_REP_LO;
			end
			PH_REP_LO: begin
				phase_d   = (cmds_q == 16'd0) ? PH_CNT_HI : PH_CMD;
				res.emit  = 1'b1;
				res.value = elem;
				res.run   = pend_q;
				res.last  = (cmds_q == 16'd0);
			end
			PH_LIT_HI: begin
				held_d  = in_byte;
				phase_d = PH_LIT_LO;
			end
			PH_LIT_LO: begin
				pend_d    = pend_dec;
				res.emit  = 1'b1;
				res.value = elem;
				res.run   = 16'd1;
				if (pend_dec == 16'd0) begin
					phase_d  = (cmds_q == 16'd0) ? PH_CNT_HI : PH_CMD;
					res.last = (cmds_q == 16'd0);
				end else begin
					phase_d = word_mode ? PH_LIT_HI : PH_LIT_LO;
				end
			end
			default: begin
				// count high byte, also any unused phase code
				held_d  = in_byte;
				phase_d = PH_CNT_LO;
			end
		endcase
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_CNT_HI;
			cmds_q   <= 16'd0;
			budget_q <= BUDGET_RESET;
			pend_q   <= 16'd0;
			held_q   <= 8'd0;
		end else if (advance) begin
			phase_q  <= phase_d;
			cmds_q   <= cmds_d;
			budget_q <= budget_d;
			pend_q   <= pend_d;
			held_q   <= held_d;
		end
	end

endmodule

FILE: hdl/rle_run_decoder_byte_or_word_core.sv
`timescale 1ns / 1ps
// A byte in the input register enters the parser when the output register is free, and
// any result word is registered on m_*. Throughput: one compressed byte per cycle unless
// m_tready stalls, set by the input register, the parser FSM and the output register.
// Reset: arst_n clears the parser to expect a stream count, the budget register to 32256,
// word mode to bytes, and both pipeline registers to empty.
module rle_run_decoder_byte_or_word_core
	import rrd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] element_value, [31:16] run_length
	output logic        m_tlast,   // stream_end
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic        word_mode_q;
	logic [15:0] budget_reg_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_free;
	logic        advance;
	rrd_result_t res;

	// Configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_mode_q  <= 1'b0;
			budget_reg_q <= BUDGET_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WORD_MODE: word_mode_q  <= cfg_data[0];
				REG_BUDGET:    budget_reg_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Input register
	assign out_free = !m_tvalid || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	rrd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.in_byte       (byte_s1),
		.word_mode     (word_mode_q),
		.output_budget (budget_reg_q),
		.res           (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= advance && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			m_tdata <= {res.run, res.value};
			m_tlast <= res.last;
		end
	end

	// Checks
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	a_result_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.emit) |=> m_tvalid)
		else $error("parser result not registered");

	a_result_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !(advance && res.emit)) |=> !m_tvalid)
		else $error("result word repeated");

endmodule
